/* rtl/core/semq_pkg.sv */
// semq_pkg: sizes, codes and record types for the semaphore table
// used by the channel interfaces, the two memories and the top level
package semq_pkg;

   localparam int unsigned NUM_SEMS    = 64;
   localparam int unsigned QUEUE_DEPTH = 16;

   localparam int unsigned SLOT_W  = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
   localparam int unsigned QPOS_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int unsigned FILL_W  = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W   = FILL_W + 1;
   localparam int unsigned WADDR_W = $clog2(NUM_SEMS * QUEUE_DEPTH);
   localparam int unsigned COUNT_W = 15;
   localparam int unsigned INDEX_W = 6;
   localparam int unsigned VALUE_W = 16;
   localparam int unsigned WHO_W   = 16;

   typedef enum logic [1:0] {
      KIND_INIT    = 2'd0,
      KIND_DOWN    = 2'd1,
      KIND_UP      = 2'd2,
      KIND_RELEASE = 2'd3
   } req_kind_type;

   typedef enum logic [2:0] {
      STAT_OK         = 3'd0,
      STAT_SUSPENDED  = 3'd1,
      STAT_INVALID    = 3'd2,
      STAT_NEG_START  = 3'd3,
      STAT_TABLE_FULL = 3'd4,
      STAT_IN_USE     = 3'd5,
      STAT_QUEUE_FULL = 3'd6
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_WAKE
   } state_type;

   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [QPOS_W-1:0]  head;
      logic [FILL_W-1:0]  fill;
   } slot_entry_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic              in_use;
      slot_entry_type    entry;
   } slot_wr_type;

   typedef struct packed {
      logic               en;
      logic [WADDR_W-1:0] addr;
      logic [WHO_W-1:0]   data;
   } wait_wr_type;

   function automatic logic [WADDR_W-1:0] wait_addr(input logic [SLOT_W-1:0] slot,
                                                     input logic [QPOS_W-1:0] pos);
      return WADDR_W'(slot) * WADDR_W'(QUEUE_DEPTH) + WADDR_W'(pos);
   endfunction

endpackage

/* rtl/core/semq_if.sv */
// semq_req_if / semq_rsp_if: valid-ready channels for requests and responses
// payload types come from semq_pkg
interface semq_req_if;
   import semq_pkg::*;

   logic                      valid;
   logic                      ready;
   req_kind_type              req_type;
   logic [INDEX_W-1:0]        sem_index;
   logic signed [VALUE_W-1:0] start_value;
   logic [WHO_W-1:0]          requester;

   modport source (output valid, req_type, sem_index, start_value, requester,
                   input ready);
   modport sink   (input valid, req_type, sem_index, start_value, requester,
                   output ready);
endinterface

interface semq_rsp_if;
   import semq_pkg::*;

   logic               valid;
   logic               ready;
   status_type         status;
   logic [INDEX_W-1:0] granted_index;
   logic               wake_valid;
   logic [WHO_W-1:0]   wake_requester;

   modport source (output valid, status, granted_index, wake_valid, wake_requester,
                   input ready);
   modport sink   (input valid, status, granted_index, wake_valid, wake_requester,
                   output ready);
endinterface

/* rtl/core/semq_slot_mem.sv */
// semq_slot_mem: per-semaphore entry memory (count, queue head, queue fill)
// plus in-use flags and lowest-free-slot finder; uses semq_pkg
module semq_slot_mem (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          rd_en,
   input  logic [semq_pkg::SLOT_W-1:0]   rd_addr,
   output semq_pkg::slot_entry_type      rd_entry,
   output logic                          rd_in_use,
   input  semq_pkg::slot_wr_type         wr,
   output logic                          free_found,
   output logic [semq_pkg::SLOT_W-1:0]   free_slot
);
   import semq_pkg::*;

   slot_entry_type      mem_ff [NUM_SEMS];
   logic [NUM_SEMS-1:0] use_ff;
   slot_entry_type      rd_entry_ff;
   logic                rd_in_use_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.entry;
      end
      if (rd_en) begin
         rd_entry_ff  <= mem_ff[rd_addr];
         rd_in_use_ff <= use_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_ff <= '0;
      end else if (wr.en) begin
         use_ff[wr.addr] <= wr.in_use;
      end
   end

   always_comb begin
      free_found = 1'b0;
      free_slot  = '0;
      for (int i = NUM_SEMS - 1; i >= 0; i--) begin
         if (!use_ff[i]) begin
            free_found = 1'b1;
            free_slot  = SLOT_W'(i);
         end
      end
   end

   assign rd_entry  = rd_entry_ff;
   assign rd_in_use = rd_in_use_ff;

endmodule

/* rtl/core/semq_wait_mem.sv */
// semq_wait_mem: ring storage of waiting requester identities, one ring per slot
// uses semq_pkg
module semq_wait_mem (
   input  logic                         clock,
   input  logic                         rd_en,
   input  logic [semq_pkg::WADDR_W-1:0] rd_addr,
   output logic [semq_pkg::WHO_W-1:0]   rd_data,
   input  semq_pkg::wait_wr_type        wr
);
   import semq_pkg::*;

   logic [WHO_W-1:0] mem_ff [NUM_SEMS * QUEUE_DEPTH];
   logic [WHO_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/semaphore_table_with_wait_queues.sv */
// semaphore_table_with_wait_queues: top level, request sequencer and response register
// depends on semq_pkg, semq_if, semq_slot_mem, semq_wait_mem
//
//   channel   direction  contents
//   req_if    in         req_type, sem_index, start_value, requester
//   rsp_if    out        status, granted_index, wake_valid, wake_requester
//   csr_*     in         max_count write
//
// a request reads the slot memory at accept; the execute state then updates and loads the response
// an up that wakes a waiter adds a wake state for the wait memory read
// reset clears in-use flags and the sequencer; entry memories need no clearing
// a held response stalls the sequencer until taken; the next request waits for idle
module semaphore_table_with_wait_queues (
   input  logic                         clock,
   input  logic                         reset,
   semq_req_if.sink                     req_if,
   semq_rsp_if.source                   rsp_if,
   input  logic                         csr_we,
   input  logic [semq_pkg::COUNT_W-1:0] csr_wdata
);
   import semq_pkg::*;

   state_type               state_ff, state_in;
   req_kind_type            kind_ff;
   logic [SLOT_W-1:0]       slot_ff;
   logic                    idx_ok_ff;
   logic [VALUE_W-1:0]      value_ff;
   logic [WHO_W-1:0]        who_ff;
   logic [COUNT_W-1:0]      max_ff;

   logic                    rsp_valid_ff, rsp_valid_in;
   status_type              status_ff, status_in;
   logic [INDEX_W-1:0]      granted_ff, granted_in;
   logic                    wake_ff, wake_in;
   logic [WHO_W-1:0]        wake_who_ff, wake_who_in;

   logic                    accept;
   logic                    out_free;
   logic                    rsp_load;
   logic                    wake_case;

   slot_entry_type          rd_entry;
   logic                    rd_in_use;
   logic                    free_found;
   logic [SLOT_W-1:0]       free_slot;
   slot_wr_type             slot_wr;
   wait_wr_type             wait_wr;
   logic                    wait_rd_en;
   logic [WADDR_W-1:0]      wait_rd_addr;
   logic [WHO_W-1:0]        wait_rd_data;

   logic [SUM_W-1:0]        tail_sum;
   logic [QPOS_W-1:0]       tail_pos;
   logic [SUM_W-1:0]        head_sum;
   logic [QPOS_W-1:0]       head_next;
   logic                    up_over;

   assign accept   = req_if.valid && req_if.ready;
   assign out_free = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready = (state_ff == ST_IDLE) && !reset;

   semq_slot_mem u_slot (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (accept),
      .rd_addr    (SLOT_W'(req_if.sem_index)),
      .rd_entry   (rd_entry),
      .rd_in_use  (rd_in_use),
      .wr         (slot_wr),
      .free_found (free_found),
      .free_slot  (free_slot)
   );

   semq_wait_mem u_wait (
      .clock   (clock),
      .rd_en   (wait_rd_en),
      .rd_addr (wait_rd_addr),
      .rd_data (wait_rd_data),
      .wr      (wait_wr)
   );

   // queue ring positions
   always_comb begin
      tail_sum = SUM_W'(rd_entry.head) + SUM_W'(rd_entry.fill);
      if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
         tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
      end
      tail_pos = QPOS_W'(tail_sum);
      head_sum = SUM_W'(rd_entry.head) + SUM_W'(1);
      if (head_sum >= SUM_W'(QUEUE_DEPTH)) begin
         head_sum = '0;
      end
      head_next = QPOS_W'(head_sum);
      up_over   = ({1'b0, rd_entry.count} + (COUNT_W + 1)'(1)) > {1'b0, max_ff};
   end

   assign wake_case = (kind_ff == KIND_UP) && idx_ok_ff && rd_in_use
                      && (rd_entry.fill != '0);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (wake_case) begin
               state_in = ST_WAKE;
            end else if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         ST_WAKE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memory updates and response
   always_comb begin
      slot_wr        = '0;
      slot_wr.addr   = slot_ff;
      slot_wr.in_use = 1'b1;
      slot_wr.entry  = rd_entry;
      wait_wr        = '0;
      wait_wr.addr   = wait_addr(slot_ff, tail_pos);
      wait_wr.data   = who_ff;
      wait_rd_en     = 1'b0;
      wait_rd_addr   = wait_addr(slot_ff, rd_entry.head);
      rsp_load       = 1'b0;
      status_in      = STAT_OK;
      granted_in     = '0;
      wake_in        = 1'b0;
      wake_who_in    = '0;

      unique case (state_ff)
         ST_EXEC: begin
            if (wake_case) begin
               wait_rd_en           = 1'b1;
               slot_wr.en           = 1'b1;
               slot_wr.entry.head   = head_next;
               slot_wr.entry.fill   = rd_entry.fill - FILL_W'(1);
            end else if (out_free) begin
               rsp_load = 1'b1;
               if (kind_ff == KIND_INIT) begin
                  if (value_ff[VALUE_W-1]) begin
                     status_in = STAT_NEG_START;
                  end else if (!free_found) begin
                     status_in = STAT_TABLE_FULL;
                  end else begin
                     granted_in          = INDEX_W'(free_slot);
                     slot_wr.en          = 1'b1;
                     slot_wr.addr        = free_slot;
                     slot_wr.entry.count = value_ff[COUNT_W-1:0];
                     slot_wr.entry.head  = '0;
                     slot_wr.entry.fill  = '0;
                  end
               end else if (!idx_ok_ff || !rd_in_use) begin
                  status_in = STAT_INVALID;
               end else begin
                  case (kind_ff)
                     KIND_DOWN: begin
                        if (rd_entry.count != '0) begin
                           slot_wr.en          = 1'b1;
                           slot_wr.entry.count = rd_entry.count - COUNT_W'(1);
                        end else if (rd_entry.fill >= FILL_W'(QUEUE_DEPTH)) begin
                           status_in = STAT_QUEUE_FULL;
                        end else begin
                           status_in          = STAT_SUSPENDED;
                           wait_wr.en         = 1'b1;
                           slot_wr.en         = 1'b1;
                           slot_wr.entry.fill = rd_entry.fill + FILL_W'(1);
                        end
                     end
                     KIND_UP: begin
                        if (up_over) begin
                           status_in = STAT_INVALID;
                        end else begin
                           slot_wr.en          = 1'b1;
                           slot_wr.entry.count = rd_entry.count + COUNT_W'(1);
                        end
                     end
                     default: begin
                        if (rd_entry.fill != '0) begin
                           status_in = STAT_IN_USE;
                        end else begin
                           slot_wr.en     = 1'b1;
                           slot_wr.in_use = 1'b0;
                           slot_wr.entry  = '0;
                        end
                     end
                  endcase
               end
            end
         end
         ST_WAKE: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               wake_in     = 1'b1;
               wake_who_in = wait_rd_data;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         max_ff       <= '1;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            max_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         kind_ff   <= req_if.req_type;
         slot_ff   <= SLOT_W'(req_if.sem_index);
         idx_ok_ff <= (32'(req_if.sem_index) < 32'(NUM_SEMS));
         value_ff  <= req_if.start_value;
         who_ff    <= req_if.requester;
      end
      if (rsp_load) begin
         status_ff   <= status_in;
         granted_ff  <= granted_in;
         wake_ff     <= wake_in;
         wake_who_ff <= wake_who_in;
      end
   end

   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.status         = status_ff;
   assign rsp_if.granted_index  = granted_ff;
   assign rsp_if.wake_valid     = wake_ff;
   assign rsp_if.wake_requester = wake_who_ff;

endmodule
